@@ rtl/core/bfra_pkg.sv @@
// shared types, constants and datapath command codes for the range allocator
`timescale 1ns / 1ps
package bfra_pkg;

  localparam int MAX_POOLS   = 8;
  localparam int MAX_RANGES  = 16;
  localparam int COUNT_BITS  = 20;
  localparam int POOL_BITS   = $clog2(MAX_POOLS);
  localparam int RANGE_BITS  = $clog2(MAX_RANGES);
  localparam int RCNT_BITS   = RANGE_BITS + 1;
  localparam int PCNT_BITS   = POOL_BITS + 1;
  localparam int ADDR_BITS   = POOL_BITS + RANGE_BITS;
  localparam int STRIDE_BITS = 8;
  localparam int DEPTH       = MAX_POOLS * MAX_RANGES;

  localparam logic [COUNT_BITS-1:0] DEFAULT_CAP_RESET = COUNT_BITS'(65536);

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD         = 3'd1;
  localparam logic [2:0] ST_POOLS_FULL  = 3'd2;
  localparam logic [2:0] ST_RANGES_FULL = 3'd3;
  localparam logic [2:0] ST_OVERLAP     = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;

  // one free range
  typedef struct packed {
    logic [COUNT_BITS-1:0] len;
    logic [COUNT_BITS-1:0] start;
  } rng_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_BAD,
    OP_SCAN,
    OP_SET_POOLS_FULL,
    OP_OPEN,
    OP_ALLOC_CUT,
    OP_ALLOC_DEL,
    OP_RD_KP1,
    OP_WR_K_INC,
    OP_DEC_CNT,
    OP_RD_R,
    OP_AT_END,
    OP_TAKE_PREV,
    OP_TAKE_NEXT,
    OP_SET_OVERLAP,
    OP_JOIN_BOTH,
    OP_JOIN_PREV,
    OP_JOIN_NEXT,
    OP_SET_RANGES_FULL,
    OP_INS_BEGIN,
    OP_RD_KM1,
    OP_WR_K_DEC,
    OP_INSERT,
    OP_EMIT
  } dp_op_t;

  // status flags from datapath to controller
  typedef struct packed {
    logic bad;
    logic alloc;
    logic scan_end;
    logic found;
    logic pools_full;
    logic exact;
    logic k_last;
    logic r_at_end;
    logic rd_below;
    logic overlap;
    logic join_prev;
    logic join_next;
    logic rel_full;
    logic k_at;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/bfra_ctrl.sv @@
// controller state machine sequencing the allocator datapath
`timescale 1ns / 1ps
module bfra_ctrl import bfra_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_fire,
  input  dp_stat_t st,
  output logic     idle,
  output dp_op_t   op
);

  typedef enum logic [13:0] {
    S_IDLE        = 14'b00000000000001,
    S_CHECK       = 14'b00000000000010,
    S_SCAN        = 14'b00000000000100,
    S_DRAIN       = 14'b00000000001000,
    S_ALLOC_DEC   = 14'b00000000010000,
    S_DN_RD       = 14'b00000000100000,
    S_DN_WR       = 14'b00000001000000,
    S_REL_RD      = 14'b00000010000000,
    S_REL_EV      = 14'b00000100000000,
    S_REL_DEC     = 14'b00001000000000,
    S_UP_RD       = 14'b00010000000000,
    S_UP_WR       = 14'b00100000000000,
    S_DONE        = 14'b01000000000000,
    S_SPARE       = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          op         = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.bad) begin
          op         = OP_SET_BAD;
          state_next = S_DONE;
        end else if (st.alloc) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_REL_RD;
        end
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (st.scan_end) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_ALLOC_DEC;
      S_ALLOC_DEC: begin
        if (!st.found) begin
          if (st.pools_full) begin
            op = OP_SET_POOLS_FULL;
          end else begin
            op = OP_OPEN;
          end
          state_next = S_DONE;
        end else if (st.exact) begin
          op         = OP_ALLOC_DEL;
          state_next = S_DN_RD;
        end else begin
          op         = OP_ALLOC_CUT;
          state_next = S_DONE;
        end
      end
      S_DN_RD: begin
        if (st.k_last) begin
          op         = OP_DEC_CNT;
          state_next = S_DONE;
        end else begin
          op         = OP_RD_KP1;
          state_next = S_DN_WR;
        end
      end
      S_DN_WR: begin
        op         = OP_WR_K_INC;
        state_next = S_DN_RD;
      end
      S_REL_RD: begin
        if (st.r_at_end) begin
          op         = OP_AT_END;
          state_next = S_REL_DEC;
        end else begin
          op         = OP_RD_R;
          state_next = S_REL_EV;
        end
      end
      S_REL_EV: begin
        if (st.rd_below) begin
          op         = OP_TAKE_PREV;
          state_next = S_REL_RD;
        end else begin
          op         = OP_TAKE_NEXT;
          state_next = S_REL_DEC;
        end
      end
      S_REL_DEC: begin
        if (st.overlap) begin
          op         = OP_SET_OVERLAP;
          state_next = S_DONE;
        end else if (st.join_prev && st.join_next) begin
          op         = OP_JOIN_BOTH;
          state_next = S_DN_RD;
        end else if (st.join_prev) begin
          op         = OP_JOIN_PREV;
          state_next = S_DONE;
        end else if (st.join_next) begin
          op         = OP_JOIN_NEXT;
          state_next = S_DONE;
        end else if (st.rel_full) begin
          op         = OP_SET_RANGES_FULL;
          state_next = S_DONE;
        end else begin
          op         = OP_INS_BEGIN;
          state_next = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (st.k_at) begin
          op         = OP_INSERT;
          state_next = S_DONE;
        end else begin
          op         = OP_RD_KM1;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        op         = OP_WR_K_DEC;
        state_next = S_UP_RD;
      end
      S_DONE: begin
        if (st.out_free) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/bfra_dp.sv @@
// datapath: pool tables, free range memory, search and update logic, result register
`timescale 1ns / 1ps
module bfra_dp import bfra_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_op_t                 op,
  output dp_stat_t               st,
  input  logic                   cfg_we,
  input  logic [COUNT_BITS-1:0]  cfg_wdata,
  input  logic                   in_command,
  input  logic [COUNT_BITS-1:0]  in_count,
  input  logic [STRIDE_BITS-1:0] in_stride,
  input  logic [POOL_BITS-1:0]   in_pool,
  input  logic [COUNT_BITS-1:0]  in_offset,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_status,
  output logic [POOL_BITS-1:0]   out_pool,
  output logic [COUNT_BITS-1:0]  out_offset,
  output logic [COUNT_BITS-1:0]  out_count,
  output logic                   out_opened
);

  logic [COUNT_BITS-1:0]  def_cap;
  logic [PCNT_BITS-1:0]   pools_open;
  logic [STRIDE_BITS-1:0] stride_tab [MAX_POOLS];
  logic [COUNT_BITS-1:0]  cap_tab    [MAX_POOLS];
  logic [RCNT_BITS-1:0]   rng_cnt    [MAX_POOLS];
  rng_t                   rng_mem    [DEPTH];
  rng_t                   rd_q;

  logic                   rq_cmd;
  logic [COUNT_BITS-1:0]  rq_count;
  logic [STRIDE_BITS-1:0] rq_stride;
  logic [POOL_BITS-1:0]   rq_pool;
  logic [COUNT_BITS-1:0]  rq_off;

  logic [POOL_BITS-1:0]   wp;
  logic [RCNT_BITS-1:0]   k;
  logic [PCNT_BITS-1:0]   sc_p;
  logic [RANGE_BITS-1:0]  sc_r;
  logic                   ev_v;
  logic [POOL_BITS-1:0]   ev_p;
  logic [RANGE_BITS-1:0]  ev_r;
  logic                   found;
  logic [POOL_BITS-1:0]   bp;
  logic [RANGE_BITS-1:0]  br;
  logic [COUNT_BITS-1:0]  bw;
  rng_t                   best;
  logic [RCNT_BITS-1:0]   rr;
  logic [RCNT_BITS-1:0]   at;
  logic                   has_prev;
  logic                   has_next;
  rng_t                   prev;
  rng_t                   nxt;

  logic [2:0]             res_status;
  logic [POOL_BITS-1:0]   res_pool;
  logic [COUNT_BITS-1:0]  res_off;
  logic [COUNT_BITS-1:0]  res_count;
  logic                   res_opened;

  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr;
  rng_t                   mem_wdata;
  logic [ADDR_BITS-1:0]   mem_raddr;

  logic [POOL_BITS-1:0]   sc_pi;
  logic                   sc_match;
  logic                   sc_entry;
  logic [COUNT_BITS-1:0]  ev_waste;
  logic                   ev_take;
  logic [COUNT_BITS-1:0]  new_cap;
  logic [POOL_BITS-1:0]   po;
  logic [COUNT_BITS:0]    prev_end;
  logic [COUNT_BITS:0]    rel_end;
  logic [COUNT_BITS-1:0]  rq_cap;
  logic [RCNT_BITS-1:0]   k_inc;
  logic [RCNT_BITS-1:0]   k_dec;
  logic [RCNT_BITS-1:0]   at_dec;

  assign sc_pi    = sc_p[POOL_BITS-1:0];
  assign sc_match = (sc_p < pools_open) && (stride_tab[sc_pi] == rq_stride);
  assign sc_entry = sc_match && ({1'b0, sc_r} < rng_cnt[sc_pi]);
  assign ev_waste = rd_q.len - rq_count;
  assign ev_take  = ev_v && (rd_q.len >= rq_count) && (!found || ev_waste < bw);
  assign new_cap  = (def_cap > rq_count) ? def_cap : rq_count;
  assign po       = pools_open[POOL_BITS-1:0];
  assign prev_end = {1'b0, prev.start} + {1'b0, prev.len};
  assign rel_end  = {1'b0, rq_off} + {1'b0, rq_count};
  assign rq_cap   = cap_tab[rq_pool];
  assign k_inc    = k + 1'b1;
  assign k_dec    = k - 1'b1;
  assign at_dec   = at - 1'b1;

  // status towards the controller
  always_comb begin
    st.alloc      = (rq_cmd == CMD_ALLOC);
    if (rq_cmd == CMD_ALLOC) begin
      st.bad = (rq_count == '0) || (rq_stride == '0) || (def_cap == '0);
    end else begin
      st.bad = ({1'b0, rq_pool} >= pools_open) || (rq_count == '0) ||
               (rq_count > rq_cap) || (rq_off > rq_cap - rq_count);
    end
    st.scan_end   = (sc_p >= pools_open);
    st.found      = found;
    st.pools_full = (pools_open >= PCNT_BITS'(MAX_POOLS));
    st.exact      = (best.len == rq_count);
    st.k_last     = (k_inc >= rng_cnt[wp]);
    st.r_at_end   = (rr >= rng_cnt[wp]);
    st.rd_below   = (rd_q.start < rq_off);
    st.overlap    = (has_prev && (prev_end > {1'b0, rq_off})) ||
                    (has_next && (rel_end > {1'b0, nxt.start}));
    st.join_prev  = has_prev && (prev_end == {1'b0, rq_off});
    st.join_next  = has_next && (rel_end == {1'b0, nxt.start});
    st.rel_full   = (rng_cnt[wp] >= RCNT_BITS'(MAX_RANGES));
    st.k_at       = (k <= at);
    st.out_free   = !out_valid || out_ready;
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bp, br};
    mem_wdata = rd_q;
    mem_raddr = {sc_pi, sc_r};
    case (op)
      OP_OPEN: begin
        mem_we          = 1'b1;
        mem_waddr       = {po, RANGE_BITS'(0)};
        mem_wdata.start = rq_count;
        mem_wdata.len   = new_cap - rq_count;
      end
      OP_ALLOC_CUT: begin
        mem_we          = 1'b1;
        mem_waddr       = {bp, br};
        mem_wdata.start = best.start + rq_count;
        mem_wdata.len   = best.len - rq_count;
      end
      OP_RD_KP1:   mem_raddr = {wp, k_inc[RANGE_BITS-1:0]};
      OP_RD_KM1:   mem_raddr = {wp, k_dec[RANGE_BITS-1:0]};
      OP_RD_R:     mem_raddr = {wp, rr[RANGE_BITS-1:0]};
      OP_WR_K_INC, OP_WR_K_DEC: begin
        mem_we    = 1'b1;
        mem_waddr = {wp, k[RANGE_BITS-1:0]};
        mem_wdata = rd_q;
      end
      OP_JOIN_BOTH: begin
        mem_we          = 1'b1;
        mem_waddr       = {wp, at_dec[RANGE_BITS-1:0]};
        mem_wdata.start = prev.start;
        mem_wdata.len   = prev.len + rq_count + nxt.len;
      end
      OP_JOIN_PREV: begin
        mem_we          = 1'b1;
        mem_waddr       = {wp, at_dec[RANGE_BITS-1:0]};
        mem_wdata.start = prev.start;
        mem_wdata.len   = prev.len + rq_count;
      end
      OP_JOIN_NEXT: begin
        mem_we          = 1'b1;
        mem_waddr       = {wp, at[RANGE_BITS-1:0]};
        mem_wdata.start = rq_off;
        mem_wdata.len   = nxt.len + rq_count;
      end
      OP_INSERT: begin
        mem_we          = 1'b1;
        mem_waddr       = {wp, at[RANGE_BITS-1:0]};
        mem_wdata.start = rq_off;
        mem_wdata.len   = rq_count;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) rng_mem[mem_waddr] <= mem_wdata;
    rd_q <= rng_mem[mem_raddr];
  end

  // control state: open pool count, range counts, register, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      def_cap    <= DEFAULT_CAP_RESET;
      pools_open <= '0;
      for (int i = 0; i < MAX_POOLS; i++) rng_cnt[i] <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) def_cap <= cfg_wdata;
      if (op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_OPEN: begin
          pools_open  <= pools_open + 1'b1;
          rng_cnt[po] <= (new_cap == rq_count) ? RCNT_BITS'(0) : RCNT_BITS'(1);
        end
        OP_DEC_CNT: rng_cnt[wp] <= rng_cnt[wp] - 1'b1;
        OP_INSERT:  rng_cnt[wp] <= rng_cnt[wp] + 1'b1;
        default: ;
      endcase
    end
  end

  // working registers and pool tables
  always_ff @(posedge clk) begin
    ev_v <= (op == OP_SCAN) && !st.scan_end && sc_entry;
    if (ev_take) begin
      found <= 1'b1;
      bp    <= ev_p;
      br    <= ev_r;
      bw    <= ev_waste;
      best  <= rd_q;
    end
    case (op)
      OP_LOAD: begin
        rq_cmd    <= in_command;
        rq_count  <= in_count;
        rq_stride <= in_stride;
        rq_pool   <= in_pool;
        rq_off    <= in_offset;
        wp        <= in_pool;
        sc_p      <= '0;
        sc_r      <= '0;
        found     <= 1'b0;
        rr        <= '0;
        has_prev  <= 1'b0;
        has_next  <= 1'b0;
      end
      OP_SCAN: begin
        if (!st.scan_end) begin
          ev_p <= sc_pi;
          ev_r <= sc_r;
          if (sc_entry && ({1'b0, sc_r} + 1'b1 < rng_cnt[sc_pi])) begin
            sc_r <= sc_r + 1'b1;
          end else begin
            sc_p <= sc_p + 1'b1;
            sc_r <= '0;
          end
        end
      end
      OP_SET_BAD, OP_SET_POOLS_FULL, OP_SET_OVERLAP, OP_SET_RANGES_FULL: begin
        res_status <= (op == OP_SET_BAD)        ? ST_BAD :
                      (op == OP_SET_POOLS_FULL) ? ST_POOLS_FULL :
                      (op == OP_SET_OVERLAP)    ? ST_OVERLAP : ST_RANGES_FULL;
        res_pool   <= '0;
        res_off    <= '0;
        res_count  <= '0;
        res_opened <= 1'b0;
      end
      OP_OPEN: begin
        stride_tab[po] <= rq_stride;
        cap_tab[po]    <= new_cap;
        res_status     <= ST_OK;
        res_pool       <= po;
        res_off        <= '0;
        res_count      <= rq_count;
        res_opened     <= 1'b1;
      end
      OP_ALLOC_CUT, OP_ALLOC_DEL: begin
        res_status <= ST_OK;
        res_pool   <= bp;
        res_off    <= best.start;
        res_count  <= rq_count;
        res_opened <= 1'b0;
        wp         <= bp;
        k          <= {1'b0, br};
      end
      OP_WR_K_INC: k <= k_inc;
      OP_WR_K_DEC: k <= k_dec;
      OP_AT_END:   at <= rr;
      OP_TAKE_PREV: begin
        prev     <= rd_q;
        has_prev <= 1'b1;
        rr       <= rr + 1'b1;
      end
      OP_TAKE_NEXT: begin
        nxt      <= rd_q;
        has_next <= 1'b1;
        at       <= rr;
      end
      OP_JOIN_BOTH, OP_JOIN_PREV, OP_JOIN_NEXT, OP_INS_BEGIN: begin
        res_status <= ST_OK;
        res_pool   <= '0;
        res_off    <= '0;
        res_count  <= '0;
        res_opened <= 1'b0;
        k          <= (op == OP_INS_BEGIN) ? rng_cnt[wp] : at;
      end
      OP_EMIT: begin
        out_status <= res_status;
        out_pool   <= res_pool;
        out_offset <= res_off;
        out_count  <= res_count;
        out_opened <= res_opened;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/best_fit_range_allocator_core.sv @@
// top level of the best-fit range allocator with coalescing release
`timescale 1ns / 1ps
//  channel  | dir | tdata (low bit up)                          | tuser
//  s_*      | in  | count[20] stride[8] pool_index[3] offset[20] | command
//  m_*      | out | granted_pool[3] granted_offset[20]          | status[3]
//           |     | granted_count[20] opened_pool[1]            |
//  cfg_*    | in  | default_capacity[20], write on cfg_we        | -
//
// one request at a time; an allocate scans each open pool, stepping through every free range
// of each pool of matching stride (up to 128), and shifts entries down on an exact fit;
// a release reads the free ranges below its offset, and shifts entries on a merge of both
// neighbours or an insert
// s_tready is high only while idle; a finished result waits in the output register
// synchronous reset clears the open pool count, range counts and output valid
module best_fit_range_allocator_core import bfra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [55:0]           s_tdata,   // count, stride, pool_index, offset, zero fill
  input  logic [0:0]            s_tuser,   // command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // granted_pool, granted_offset, granted_count,
                                           // opened_pool, zero fill
  output logic [2:0]            m_tuser,   // status
  input  logic                  cfg_we,
  input  logic [COUNT_BITS-1:0] cfg_wdata  // default_capacity
);

  dp_op_t   op;
  dp_stat_t st;
  logic     idle;
  logic     req_fire;

  logic [POOL_BITS-1:0]  out_pool;
  logic [COUNT_BITS-1:0] out_offset;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_opened;

  assign s_tready = idle;
  assign req_fire = s_tvalid && idle;

  bfra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_fire (req_fire),
    .st       (st),
    .idle     (idle),
    .op       (op)
  );

  bfra_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .st         (st),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_command (s_tuser[0]),
    .in_count   (s_tdata[19:0]),
    .in_stride  (s_tdata[27:20]),
    .in_pool    (s_tdata[30:28]),
    .in_offset  (s_tdata[50:31]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_pool   (out_pool),
    .out_offset (out_offset),
    .out_count  (out_count),
    .out_opened (out_opened)
  );

  // result packing, zero fill to whole bytes
  assign m_tdata = {4'b0000, out_opened, out_count, out_offset, out_pool};

endmodule

@@ rtl/core/bfra_checker.sv @@
// port-level assertions for the allocator core and their binding
`timescale 1ns / 1ps
module bfra_checker import bfra_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [47:0]           m_tdata,
  input logic [2:0]            m_tuser
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // no result in the cycle right after a request
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result too early");

  // failures carry no grant
  a_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("grant fields set on failure");

  // a fresh pool is granted from its start
  a_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[43] |-> (m_tdata[22:3] == '0) && (m_tuser == ST_OK))
    else $error("new pool grant not at offset zero");

endmodule

bind best_fit_range_allocator_core bfra_checker u_bfra_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ sim/bfra_checker.sv @@
// request/result scoreboard with a behavioural model of the range allocator
`timescale 1ns / 1ps
module bfra_scoreboard import bfra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [55:0]           s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [47:0]           m_tdata,
  input  logic [2:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [COUNT_BITS-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    n_grants,
  output int                    n_frees,
  output int                    n_refusals
);

  typedef struct packed {
    logic [2:0]            status;
    logic [POOL_BITS-1:0]  pool;
    logic [COUNT_BITS-1:0] offset;
    logic [COUNT_BITS-1:0] count;
    logic                  opened;
  } grant_t;

  grant_t grant_q[$];

  logic [COUNT_BITS-1:0] cap_default;
  int unsigned           n_pools;
  logic [7:0]            p_stride [MAX_POOLS];
  int unsigned           p_cap    [MAX_POOLS];
  int unsigned           p_nfree  [MAX_POOLS];
  int unsigned           f_start  [MAX_POOLS][MAX_RANGES];
  int unsigned           f_len    [MAX_POOLS][MAX_RANGES];

  function automatic void drop_range(int unsigned p, int unsigned r);
    for (int unsigned k = r; k + 1 < p_nfree[p]; k++) begin
      f_start[p][k] = f_start[p][k+1];
      f_len[p][k]   = f_len[p][k+1];
    end
    p_nfree[p]--;
  endfunction

  function automatic grant_t model_alloc(int unsigned cnt, int unsigned str);
    grant_t g;
    bit found;
    int unsigned bp, br, bw, cap, off;
    g = '0;
    found = 0; bp = 0; br = 0; bw = 0;
    if (cnt == 0 || str == 0 || cap_default == 0) begin
      g.status = ST_BAD;
      return g;
    end
    for (int unsigned p = 0; p < n_pools; p++) begin
      if (p_stride[p] != str) continue;
      for (int unsigned r = 0; r < p_nfree[p]; r++) begin
        if (f_len[p][r] < cnt) continue;
        if (!found || f_len[p][r] - cnt < bw) begin
          found = 1; bp = p; br = r; bw = f_len[p][r] - cnt;
        end
      end
    end
    if (!found) begin
      if (n_pools >= MAX_POOLS) begin
        g.status = ST_POOLS_FULL;
        return g;
      end
      cap = (cap_default > cnt) ? cap_default : cnt;
      bp = n_pools; br = 0;
      p_stride[bp] = 8'(str); p_cap[bp] = cap; p_nfree[bp] = 1;
      f_start[bp][0] = 0; f_len[bp][0] = cap;
      n_pools++;
      g.opened = 1;
    end
    off = f_start[bp][br];
    if (f_len[bp][br] == cnt) drop_range(bp, br);
    else begin
      f_start[bp][br] = off + cnt;
      f_len[bp][br]   = f_len[bp][br] - cnt;
    end
    g.status = ST_OK;
    g.pool   = POOL_BITS'(bp);
    g.offset = COUNT_BITS'(off);
    g.count  = COUNT_BITS'(cnt);
    return g;
  endfunction

  function automatic logic [2:0] model_release(int unsigned p, int unsigned off,
                                               int unsigned cnt);
    int unsigned n, at, fin, pe;
    bit jp, jn;
    at = 0; jp = 0; jn = 0;
    if (p >= n_pools || cnt == 0) return ST_BAD;
    if (cnt > p_cap[p] || off > p_cap[p] - cnt) return ST_BAD;
    n = p_nfree[p];
    while (at < n && f_start[p][at] < off) at++;
    fin = off + cnt;
    if (at > 0) begin
      pe = f_start[p][at-1] + f_len[p][at-1];
      if (pe > off) return ST_OVERLAP;
      jp = (pe == off);
    end
    if (at < n) begin
      if (fin > f_start[p][at]) return ST_OVERLAP;
      jn = (fin == f_start[p][at]);
    end
    if (jp && jn) begin
      f_len[p][at-1] = f_len[p][at-1] + cnt + f_len[p][at];
      drop_range(p, at);
    end else if (jp) begin
      f_len[p][at-1] = f_len[p][at-1] + cnt;
    end else if (jn) begin
      f_start[p][at] = off;
      f_len[p][at]   = f_len[p][at] + cnt;
    end else begin
      if (n >= MAX_RANGES) return ST_RANGES_FULL;
      for (int unsigned k = n; k > at; k--) begin
        f_start[p][k] = f_start[p][k-1];
        f_len[p][k]   = f_len[p][k-1];
      end
      f_start[p][at] = off;
      f_len[p][at]   = cnt;
      p_nfree[p]     = n + 1;
    end
    return ST_OK;
  endfunction

  always @(posedge clk) begin
    grant_t g, got;
    if (rst) begin
      cap_default = DEFAULT_CAP_RESET;
      n_pools = 0;
      for (int p = 0; p < MAX_POOLS; p++) p_nfree[p] = 0;
      grant_q.delete();
      fail_count = 0; n_grants = 0; n_frees = 0; n_refusals = 0;
    end else begin
      if (cfg_we) cap_default = cfg_wdata;
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == CMD_ALLOC) begin
          g = model_alloc(32'(s_tdata[19:0]), 32'(s_tdata[27:20]));
        end else begin
          g = '0;
          g.status = model_release(32'(s_tdata[30:28]), 32'(s_tdata[50:31]),
                                   32'(s_tdata[19:0]));
        end
        if (g.status != ST_OK) n_refusals++;
        else if (s_tuser[0] == CMD_ALLOC) n_grants++;
        else n_frees++;
        grant_q.push_back(g);
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[2:0], m_tdata[22:3], m_tdata[42:23], m_tdata[43]};
        if (grant_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          g = grant_q.pop_front();
          if (got !== g) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch: exp st=%0d pool=%0d off=%0d cnt=%0d open=%0d",
                        " | got st=%0d pool=%0d off=%0d cnt=%0d open=%0d"},
                       g.status, g.pool, g.offset, g.count, g.opened,
                       got.status, got.pool, got.offset, got.count, got.opened);
          end
        end
      end
    end
    pending = grant_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
// stimulus and verdict for the best-fit range allocator regression
`timescale 1ns / 1ps
module tb_top;
  import bfra_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN       = 400;   // beyond the slowest scan plus shifts

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [55:0]           s_tdata;
  logic [0:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [47:0]           m_tdata;
  logic [2:0]            m_tuser;
  logic                  cfg_we;
  logic [COUNT_BITS-1:0] cfg_wdata;

  int fail_count, pending, n_grants, n_frees, n_refusals;
  int n_acc;
  int cycles;
  bit quiet;     // no idling in the closing stretch
  bit hold_go;   // asks the receiver for one long hold-off

  // live grants seen on the result channel: pool, offset, count
  typedef struct packed {
    logic [2:0]  pool;
    logic [19:0] offset;
    logic [19:0] count;
  } span_t;
  span_t live[$];
  span_t last_freed;

  best_fit_range_allocator_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  bfra_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending),
    .n_grants(n_grants), .n_frees(n_frees), .n_refusals(n_refusals)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // accepted requests, and grants kept for later release
  always @(posedge clk) begin
    if (rst) n_acc <= 0;
    else if (s_tvalid && s_tready) n_acc <= n_acc + 1;
    if (!rst && m_tvalid && m_tready && m_tuser == ST_OK && m_tdata[42:23] != 0)
      live.push_back({m_tdata[2:0], m_tdata[22:3], m_tdata[42:23]});
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin
    bit held;
    held = 0;
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_go && !held) begin
        held = 1;
        m_tready <= 0;
        repeat (600) @(negedge clk);
      end else if (!quiet && !rst && $urandom_range(4) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(2)) @(negedge clk);
      end else begin
        m_tready <= 1;
      end
    end
  end

  // one request, with an optional gap before it; returns at the falling edge after acceptance
  task automatic send(bit cmd, logic [19:0] cnt, logic [7:0] str, logic [2:0] pl,
                      logic [19:0] off);
    int tgt;
    if (!quiet && $urandom_range(3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tdata  <= {5'b0, off, pl, str, cnt};
    s_tuser  <= cmd;
    s_tvalid <= 1;
    tgt = n_acc + 1;
    wait (n_acc == tgt);
    @(negedge clk);
  endtask

  // let the block drain before touching the register
  task automatic settle();
    s_tvalid <= 0;
    wait (pending == 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_capacity(logic [19:0] cap);
    settle();
    cfg_we    <= 1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 0;
    @(negedge clk);
  endtask

  // random request: mostly allocate and release of live spans, some noise
  task automatic random_request();
    int    pick, idx;
    span_t sp;
    logic [19:0] cnt, part;
    logic [7:0]  str;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // raw noise, every bit free
      send(1'($urandom_range(1)), 20'($urandom), 8'($urandom), 3'($urandom),
           20'($urandom));
    end else if (pick < 12) begin
      // free the last freed span again: normally overlaps
      send(1'b1, last_freed.count, 8'($urandom), last_freed.pool, last_freed.offset);
    end else if (pick < 55 && live.size() > 0) begin
      idx = $urandom_range(live.size() - 1);
      sp = live[idx];
      live.delete(idx);
      case ($urandom_range(2))
        0: begin
          send(1'b1, sp.count, 8'($urandom), sp.pool, sp.offset);
          last_freed = sp;
        end
        1: begin
          // front part only, back remains live
          part = (sp.count > 1) ? 20'($urandom_range(1, sp.count - 1)) : sp.count;
          send(1'b1, part, 8'($urandom), sp.pool, sp.offset);
          last_freed = {sp.pool, sp.offset, part};
          if (part < sp.count) live.push_back({sp.pool, sp.offset + part, sp.count - part});
        end
        default: begin
          // back part only, front remains live
          part = (sp.count > 1) ? 20'($urandom_range(1, sp.count - 1)) : sp.count;
          send(1'b1, part, 8'($urandom), sp.pool, sp.offset + sp.count - part);
          last_freed = {sp.pool, sp.offset + sp.count - part, part};
          if (part < sp.count) live.push_back({sp.pool, sp.offset, sp.count - part});
        end
      endcase
    end else begin
      case ($urandom_range(19))
        0:       cnt = 20'($urandom_range(1, 20'hFFFFF));
        1, 2:    cnt = 20'($urandom_range(1, 4096));
        default: cnt = 20'($urandom_range(1, 64));
      endcase
      str = ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255)) :
                                       8'($urandom_range(1, 4));
      send(1'b0, cnt, str, 3'($urandom), 20'($urandom));
    end
  endtask

  initial begin
    logic [19:0] caps [4];
    caps = '{20'd65536, 20'hFFFFF, 20'd1, 20'd4096};
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tuser = '0;
    cfg_we = 0; cfg_wdata = '0; quiet = 0; hold_go = 0;
    last_freed = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: rejections, extremes, merges, overlap, unopened pool
    send(1'b0, 20'd0, 8'd1, 3'd0, 20'd0);          // zero count
    send(1'b0, 20'd5, 8'd0, 3'd7, 20'hFFFFF);      // zero stride
    send(1'b1, 20'd1, 8'd1, 3'd0, 20'd0);          // no pool open yet
    send(1'b0, 20'd1, 8'd1, 3'd0, 20'd0);          // opens pool 0
    send(1'b0, 20'hFFFFF, 8'd255, 3'd0, 20'd0);    // largest count, own pool
    send(1'b0, 20'd10, 8'd1, 3'd0, 20'd0);
    send(1'b0, 20'd10, 8'd1, 3'd0, 20'd0);
    send(1'b1, 20'd0, 8'd0, 3'd0, 20'd1);          // zero count release
    send(1'b1, 20'd1, 8'd0, 3'd0, 20'hFFFFF);      // past the capacity
    send(1'b1, 20'd5, 8'd0, 3'd0, 20'd100);        // already free: overlap
    send(1'b1, 20'd10, 8'd0, 3'd0, 20'd1);         // hole, no neighbour
    send(1'b1, 20'd1, 8'd0, 3'd0, 20'd0);          // joins the next range
    send(1'b1, 20'd10, 8'd0, 3'd0, 20'd11);        // joins both sides
    send(1'b1, 20'hFFFFF, 8'hFF, 3'd1, 20'd0);     // whole of pool 1, exact
    send(1'b0, 20'hFFFFF, 8'd255, 3'd7, 20'hFFFFF);// exact fit of a whole pool
    send(1'b1, 20'd1, 8'd0, 3'd7, 20'd0);          // unopened pool 7
    for (int i = 0; i < 7; i++) send(1'b0, 20'd70000, 8'(10 + i), 3'd0, 20'd0);

    // random phases over several capacity settings
    for (int ph = 0; ph < 4; ph++) begin
      set_capacity(caps[ph]);
      for (int i = 0; i < 225; i++) begin
        if (ph == 1 && i == 20) hold_go = 1;   // receiver backs up the block
        if (ph == 2 && i == 100) settle();     // sender waits for every result
        if (ph == 3 && i == 75) quiet = 1;
        random_request();
      end
    end

    s_tvalid <= 0;
    wait (pending == 0);
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d grants, %0d frees, %0d refused requests over four capacities",
             n_grants, n_frees, n_refusals);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
